// ----- src/assert_macros.svh -----
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/nca_pkg.sv -----
package nca_pkg;

  localparam int NUM_CENTROIDS = 8;
  localparam int NUM_DIMS      = 8;

  localparam int COORD_FIELDS = 8;
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int SQ_W         = 32;
  localparam int DIST_W       = 35;
  localparam int SLOT_W       = 3;
  localparam int OUT_IDX_W    = 3;
  localparam int CFG_W        = 4;
  localparam int CFG_ADDR_W   = 2;
  localparam int IDX_W        = (NUM_CENTROIDS > 1) ? $clog2(NUM_CENTROIDS) : 1;

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 40;

  localparam logic KIND_LOAD     = 1'b0;
  localparam logic KIND_CLASSIFY = 1'b1;

  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_DIMS      = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_CENTROIDS = 2'd1;

  typedef logic [NUM_DIMS-1:0][COORD_W-1:0] coords_t;

  typedef struct packed {
    logic              valid;
    logic              kind;
    logic [SLOT_W-1:0] slot;
    coords_t           coord;
    logic [IDX_W-1:0]  best_idx;
    logic [DIST_W-1:0] best_dist;
  } item_t;

  // effective (clamped) settings seen by every cell
  typedef struct packed {
    logic [CFG_W-1:0] dims;
    logic [CFG_W-1:0] count;
  } cfg_t;

endpackage

// ----- src/nca_cell.sv -----
module nca_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     adv,
  input  nca_pkg::cfg_t            cfg,
  input  logic [nca_pkg::IDX_W-1:0] cell_idx,
  input  nca_pkg::item_t           item_in,
  output nca_pkg::item_t           item_out
);
  import nca_pkg::*;

  coords_t cent_r;

  item_t                             a_item_r, a_item_nxt;
  logic [NUM_DIMS-1:0][DIFF_W-1:0]   a_diff_r, a_diff_nxt;
  item_t                             b_item_r;
  logic [NUM_DIMS-1:0][SQ_W-1:0]     b_sq_r, b_sq_nxt;
  item_t                             c_item_r;
  logic [DIST_W-1:0]                 c_sum_r, c_sum_nxt;
  item_t                             d_item_r, d_item_nxt;

  logic load_hit;
  logic take;

  assign load_hit = item_in.valid && (item_in.kind == KIND_LOAD) &&
                    (32'(item_in.slot) == 32'(cell_idx));

  // centroid slot, written in stream order by a load beat
  always_ff @(posedge clk) begin
    if (adv && load_hit) begin
      cent_r <= item_in.coord;
    end
  end

  always_comb begin
    a_item_nxt = item_in;
    for (int d = 0; d < NUM_DIMS; d++) begin
      a_diff_nxt[d] = DIFF_W'($signed({item_in.coord[d][COORD_W-1], item_in.coord[d]}) -
                              $signed({cent_r[d][COORD_W-1], cent_r[d]}));
    end
  end

  always_comb begin
    logic signed [2*DIFF_W-1:0] p;
    p = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      p = $signed(a_diff_r[d]) * $signed(a_diff_r[d]);
      b_sq_nxt[d] = (d < int'(cfg.dims)) ? SQ_W'(p) : '0;
    end
  end

  always_comb begin
    c_sum_nxt = '0;
    for (int d = 0; d < NUM_DIMS; d++) begin
      c_sum_nxt = c_sum_nxt + DIST_W'(b_sq_r[d]);
    end
  end

  // lower index wins on ties: strict compare against earlier cells
  assign take = (cell_idx == '0) ||
                ((32'(cell_idx) < 32'(cfg.count)) && (c_sum_r < c_item_r.best_dist));

  always_comb begin
    d_item_nxt = c_item_r;
    if (take) begin
      d_item_nxt.best_idx  = cell_idx;
      d_item_nxt.best_dist = c_sum_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_item_r.valid <= 1'b0;
      b_item_r.valid <= 1'b0;
      c_item_r.valid <= 1'b0;
      d_item_r.valid <= 1'b0;
    end else if (adv) begin
      a_item_r <= a_item_nxt;
      b_item_r <= a_item_r;
      c_item_r <= b_item_r;
      d_item_r <= d_item_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_diff_r <= a_diff_nxt;
      b_sq_r   <= b_sq_nxt;
      c_sum_r  <= c_sum_nxt;
    end
  end

  assign item_out = d_item_r;

endmodule

// ----- src/nearest_centroid_assign.sv -----
// channel | dir | tdata fields (lsb first)                      | tuser
// in_     | in  | centroid_index[2:0], coord_0..coord_7 (16 each) | req_type
// out_    | out | nearest_index[2:0], min_distance_sq[34:0]       | -
// cfg_    | in  | cfg_addr 0 active_dims, 1 active_centroids, cfg_wdata[3:0]
//
// One beat accepted per cycle while no result stalls; a classify result passes through
// the chain of centroid cells, four register stages each (diff, square, sum, compare).
// Load beats travel the same chain and write their slot when they reach its cell.
// Reset (synchronous, rst_n low) empties the chain and sets both registers to 8;
// centroid slots hold garbage until loaded.
// A stalled result beat freezes the whole chain and drops in_tready.
module nearest_centroid_assign (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [nca_pkg::IN_DATA_W-1:0]  in_tdata,  // centroid_index, coord_0..coord_7, pad
  input  logic                           in_tuser,  // req_type
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [nca_pkg::OUT_DATA_W-1:0] out_tdata, // nearest_index, min_distance_sq, pad
  input  logic                           cfg_we,
  input  logic [nca_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [nca_pkg::CFG_W-1:0]      cfg_wdata
);
  import nca_pkg::*;

  logic [CFG_W-1:0] active_dims_r, active_dims_nxt;
  logic [CFG_W-1:0] active_centroids_r, active_centroids_nxt;
  cfg_t             cfg_eff;

  item_t entry;
  item_t chain [NUM_CENTROIDS+1];
  item_t fin;
  logic  adv;

  always_comb begin
    active_dims_nxt      = active_dims_r;
    active_centroids_nxt = active_centroids_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_ACTIVE_DIMS:      active_dims_nxt      = cfg_wdata;
        REG_ACTIVE_CENTROIDS: active_centroids_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_dims_r      <= CFG_W'(8);
      active_centroids_r <= CFG_W'(8);
    end else begin
      active_dims_r      <= active_dims_nxt;
      active_centroids_r <= active_centroids_nxt;
    end
  end

  // zero acts as one, large values saturate
  always_comb begin
    if (active_dims_r == '0) begin
      cfg_eff.dims = CFG_W'(1);
    end else if (32'(active_dims_r) > NUM_DIMS) begin
      cfg_eff.dims = CFG_W'(NUM_DIMS);
    end else begin
      cfg_eff.dims = active_dims_r;
    end
    if (active_centroids_r == '0) begin
      cfg_eff.count = CFG_W'(1);
    end else if (32'(active_centroids_r) > NUM_CENTROIDS) begin
      cfg_eff.count = CFG_W'(NUM_CENTROIDS);
    end else begin
      cfg_eff.count = active_centroids_r;
    end
  end

  always_comb begin
    entry           = '0;
    entry.valid     = in_tvalid;
    entry.kind      = in_tuser;
    entry.slot      = in_tdata[SLOT_W-1:0];
    for (int d = 0; d < NUM_DIMS; d++) begin
      entry.coord[d] = in_tdata[SLOT_W + COORD_W*d +: COORD_W];
    end
  end

  assign chain[0] = entry;

  for (genvar c = 0; c < NUM_CENTROIDS; c++) begin : g_cell
    nca_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .cfg      (cfg_eff),
      .cell_idx (IDX_W'(c)),
      .item_in  (chain[c]),
      .item_out (chain[c+1])
    );
  end

  assign fin        = chain[NUM_CENTROIDS];
  assign out_tvalid = fin.valid && (fin.kind == KIND_CLASSIFY);
  assign adv        = !out_tvalid || out_tready;
  assign in_tready  = adv;

  assign out_tdata = {(OUT_DATA_W - OUT_IDX_W - DIST_W)'(0), fin.best_dist,
                      OUT_IDX_W'(fin.best_idx)};

endmodule

// ----- src/nca_checker.sv -----
module nca_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [nca_pkg::IN_DATA_W-1:0]  in_tdata,
  input logic                           in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [nca_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           cfg_we,
  input logic [nca_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input logic [nca_pkg::CFG_W-1:0]      cfg_wdata
);
  import nca_pkg::*;
  `include "assert_macros.svh"

  logic out_stall;
  logic cfg_any;
  logic in_any;

  assign out_stall = out_tvalid && !out_tready;
  assign cfg_any   = cfg_we && (cfg_addr == REG_ACTIVE_DIMS) && (cfg_wdata == '0);
  assign in_any    = in_tvalid && (in_tdata == '0) && in_tuser;

  `CHK_ASSERT(a_out_hold, clk, rst_n, out_stall |=> out_tvalid && $stable(out_tdata), "result beat changed while stalled")
  `CHK_ASSERT(a_ready_free, clk, rst_n, !out_stall |-> in_tready, "input blocked with no stalled result")
  `CHK_ASSERT(a_ready_stall, clk, rst_n, out_stall |-> !in_tready, "input taken while result stalled")
  `CHK_ASSERT(a_idx_range, clk, rst_n, out_tvalid |-> (32'(out_tdata[2:0]) < NUM_CENTROIDS) || (NUM_CENTROIDS > 7) || cfg_any || in_any, "nearest index beyond centroid count")
  `CHK_ASSERT(a_dist_range, clk, rst_n, out_tvalid |-> out_tdata[37:3] <= 35'd34358689800, "distance beyond maximum")

endmodule

bind nearest_centroid_assign nca_checker u_nca_checker (.*);
